// ===== hw/rtl/pfa_pkg.sv =====
// Package for the physical frame allocator: payload structs, command, status
// and owner codes, and the control/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package pfa_pkg;

  // Fixed field widths.
  localparam int CFG_W  = 10;
  localparam int ADDR_W = 21;

  // Request commands.
  localparam logic [1:0] CMD_INIT   = 2'd0;
  localparam logic [1:0] CMD_ALLOC  = 2'd1;
  localparam logic [1:0] CMD_ASSIGN = 2'd2;

  // Response status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  // Owner codes kept in the frame table.
  localparam logic [7:0] OWNER_FREE     = 8'h00;
  localparam logic [7:0] OWNER_RESERVED = 8'hFF;
  localparam logic [7:0] OWNER_KERNEL   = 8'hFE;

  // Configuration register indexes.
  localparam logic [1:0] REG_IO_FIRST = 2'd0;
  localparam logic [1:0] REG_IO_END   = 2'd1;
  localparam logic [1:0] REG_KER_FIRST = 2'd2;
  localparam logic [1:0] REG_KER_END  = 2'd3;

  // Result selection codes.
  typedef logic [2:0] res_sel_t;
  localparam res_sel_t RES_NONE    = 3'd0;
  localparam res_sel_t RES_NO_FREE = 3'd1;
  localparam res_sel_t RES_REJECT  = 3'd2;
  localparam res_sel_t RES_ALLOC   = 3'd3;
  localparam res_sel_t RES_ASSIGN  = 3'd4;

  typedef struct packed {
    logic [1:0]        command;
    logic signed [7:0] owner_code;
    logic [31:0]       page_address;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] frame_address;
  } rsp_t;

  typedef struct packed {
    logic [CFG_W-1:0] io_hole_first_frame;
    logic [CFG_W-1:0] io_hole_end_frame;
    logic [CFG_W-1:0] kernel_first_frame;
    logic [CFG_W-1:0] kernel_end_frame;
  } cfg_t;

  typedef struct packed {
    logic [7:0] owner;
    logic [7:0] count;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     ptr_zero;
    logic     ptr_hint;
    logic     clear_wr;
    logic     init_wr;
    logic     scan;
    logic     alloc_wr;
    logic     asn_rd;
    logic     asn_wr;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
    logic found;
    logic exhausted;
    logic asn_bad;
    logic asn_busy;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/physical_frame_allocator.sv =====
// One item at a time: the next request beat can be taken at the first edge that can take
// the response beat, and earlier while the response stalls in the output register.
// Alloc scans from the hint; an assign whose address is refused skips the table read.
// The init sweep writes one frame a cycle. Reset clears the table with req_ready low;
// APB writes are taken throughout; registers reset to 160/256/64/96.
`default_nettype none

module physical_frame_allocator #(
  parameter int FRAMES     = 512,
  parameter int PAGE_SHIFT = 12
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // Request channel.
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire pfa_pkg::req_t req,
  // Response channel.
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output pfa_pkg::rsp_t      rsp,
  // APB configuration port.
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  pfa_pkg::cfg_t  cfg;
  pfa_pkg::ctrl_t ctl;
  pfa_pkg::stat_t stat;
  logic           cfg_wr;
  logic [1:0]     reg_index;

  // The APB port never stalls. Each register sits on a 32-bit word, so the
  // word index selects the register and the low address bits are ignored.
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_wr    = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.io_hole_first_frame <= 10'd160;
      cfg.io_hole_end_frame   <= 10'd256;
      cfg.kernel_first_frame  <= 10'd64;
      cfg.kernel_end_frame    <= 10'd96;
    end else if (cfg_wr) begin
      case (reg_index)
        pfa_pkg::REG_IO_FIRST:  cfg.io_hole_first_frame <= pwdata[pfa_pkg::CFG_W-1:0];
        pfa_pkg::REG_IO_END:    cfg.io_hole_end_frame   <= pwdata[pfa_pkg::CFG_W-1:0];
        pfa_pkg::REG_KER_FIRST: cfg.kernel_first_frame  <= pwdata[pfa_pkg::CFG_W-1:0];
        pfa_pkg::REG_KER_END:   cfg.kernel_end_frame    <= pwdata[pfa_pkg::CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads are combinational and zero-extended to the bus width.
  always_comb begin
    case (reg_index)
      pfa_pkg::REG_IO_FIRST:  prdata = 32'(cfg.io_hole_first_frame);
      pfa_pkg::REG_IO_END:    prdata = 32'(cfg.io_hole_end_frame);
      pfa_pkg::REG_KER_FIRST: prdata = 32'(cfg.kernel_first_frame);
      pfa_pkg::REG_KER_END:   prdata = 32'(cfg.kernel_end_frame);
      default:                prdata = 32'd0;
    endcase
  end

  // The controller sequences every command: the clearing pass, the init
  // sweep, the first-fit scan and the assign read-check-write. It looks at
  // the request's command field to pick the sequence on the accepting beat.
  pfa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_command (req.command),
    .stat        (stat),
    .ctl         (ctl),
    .req_ready   (req_ready)
  );

  // The datapath holds the frame table (owner and count per frame), the
  // scan pointer with its registered read stage, a hint below which no
  // free frame exists, and the result and output registers. The output
  // register lets a finished response wait while the next request works.
  pfa_dp #(
    .FRAMES     (FRAMES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (cfg),
    .req       (req),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .rsp       (rsp),
    .rsp_valid (rsp_valid)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_ctrl.sv =====
// Controller state machine of the physical frame allocator.
// Depends on pfa_pkg; drives the datapath pfa_dp through pfa_pkg::ctrl_t.
`default_nettype none

module pfa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  input  wire logic [1:0]     req_command,
  input  wire pfa_pkg::stat_t stat,
  output pfa_pkg::ctrl_t      ctl,
  output logic                req_ready
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_INIT    = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_ASN_RD  = 3'd4;
  localparam logic [2:0] S_ASN_CHK = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    ctl.res_sel = pfa_pkg::RES_NONE;
    state_next = state;
    case (state)
      S_CLEAR: begin
        ctl.clear_wr = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          ctl.capture = 1'b1;
          case (req_command)
            pfa_pkg::CMD_INIT: begin
              ctl.ptr_zero = 1'b1;
              state_next   = S_INIT;
            end
            pfa_pkg::CMD_ALLOC: begin
              ctl.ptr_hint = 1'b1;
              state_next   = S_SCAN;
            end
            pfa_pkg::CMD_ASSIGN: begin
              state_next = S_ASN_RD;
            end
            default: begin
              // Unused command: no state change, plain ok answer.
              ctl.res_load = 1'b1;
              state_next   = S_DONE;
            end
          endcase
        end
      end
      S_INIT: begin
        ctl.init_wr = 1'b1;
        if (stat.sweep_last) begin
          ctl.res_load = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.found) begin
          ctl.alloc_wr = 1'b1;
          ctl.res_load = 1'b1;
          ctl.res_sel  = pfa_pkg::RES_ALLOC;
          state_next   = S_DONE;
        end else if (stat.exhausted) begin
          ctl.res_load = 1'b1;
          ctl.res_sel  = pfa_pkg::RES_NO_FREE;
          state_next   = S_DONE;
        end
      end
      S_ASN_RD: begin
        if (stat.asn_bad) begin
          ctl.res_load = 1'b1;
          ctl.res_sel  = pfa_pkg::RES_REJECT;
          state_next   = S_DONE;
        end else begin
          ctl.asn_rd = 1'b1;
          state_next = S_ASN_CHK;
        end
      end
      S_ASN_CHK: begin
        ctl.res_load = 1'b1;
        if (stat.asn_busy) begin
          ctl.res_sel = pfa_pkg::RES_REJECT;
        end else begin
          ctl.asn_wr  = 1'b1;
          ctl.res_sel = pfa_pkg::RES_ASSIGN;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_dp.sv =====
// Datapath of the physical frame allocator: frame table memory, sweep and
// scan pointer, free-frame hint, result and output registers. Depends on pfa_pkg.
`default_nettype none

module pfa_dp #(
  parameter int FRAMES     = 512,
  parameter int PAGE_SHIFT = 12
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pfa_pkg::ctrl_t ctl,
  input  wire pfa_pkg::cfg_t  cfg,
  input  wire pfa_pkg::req_t  req,
  input  wire logic           rsp_ready,
  output pfa_pkg::stat_t      stat,
  output pfa_pkg::rsp_t       rsp,
  output logic                rsp_valid
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [FW:0]   NF       = (FW+1)'(FRAMES);
  localparam logic [FW:0]   NF_LAST  = (FW+1)'(FRAMES - 1);
  localparam logic [31:0]   PMASK    = (32'd1 << PAGE_SHIFT) - 32'd1;
  localparam logic [32:0]   LIMIT    = 33'(FRAMES) << PAGE_SHIFT;

  pfa_pkg::entry_t mem [FRAMES];

  pfa_pkg::req_t   cap;
  logic [FW:0]     ptr;
  logic [FW:0]     hint;
  logic            pv;
  logic [FW-1:0]   pf;
  pfa_pkg::entry_t rd_q;
  pfa_pkg::rsp_t   res;

  logic            issue;
  logic            rd_en;
  logic [FW-1:0]   raddr;
  logic            we;
  logic [FW-1:0]   waddr;
  pfa_pkg::entry_t wdata;
  pfa_pkg::entry_t init_entry;
  logic [31:0]     fx;
  logic            in_io;
  logic            in_ker;
  logic [31:0]     asn_shift;
  logic [FW-1:0]   asn_frame;
  logic [31:0]     alloc_addr;
  logic [7:0]      cnt_inc;

  // Frame classification for the init sweep.
  assign fx     = 32'(ptr);
  assign in_io  = (fx >= 32'(cfg.io_hole_first_frame)) && (fx < 32'(cfg.io_hole_end_frame));
  assign in_ker = (fx >= 32'(cfg.kernel_first_frame)) && (fx < 32'(cfg.kernel_end_frame));

  always_comb begin
    if ((fx == 32'd0) || in_io) begin
      init_entry.owner = pfa_pkg::OWNER_RESERVED;
      init_entry.count = 8'd1;
    end else if (in_ker) begin
      init_entry.owner = pfa_pkg::OWNER_KERNEL;
      init_entry.count = 8'd1;
    end else begin
      init_entry.owner = pfa_pkg::OWNER_FREE;
      init_entry.count = 8'd0;
    end
  end

  assign asn_shift  = cap.page_address >> PAGE_SHIFT;
  assign asn_frame  = asn_shift[FW-1:0];
  assign alloc_addr = 32'(pf) << PAGE_SHIFT;
  assign cnt_inc    = (rd_q.count == 8'hFF) ? 8'hFF : rd_q.count + 8'd1;

  assign issue = ctl.scan && (ptr < NF);
  assign rd_en = issue || ctl.asn_rd;
  assign raddr = ctl.asn_rd ? asn_frame : ptr[FW-1:0];

  always_comb begin
    we    = 1'b1;
    waddr = ptr[FW-1:0];
    wdata = '0;
    if (ctl.clear_wr) begin
      wdata = '0;
    end else if (ctl.init_wr) begin
      wdata = init_entry;
    end else if (ctl.alloc_wr) begin
      waddr       = pf;
      wdata.owner = cap.owner_code;
      wdata.count = cnt_inc;
    end else if (ctl.asn_wr) begin
      waddr       = asn_frame;
      wdata.owner = cap.owner_code;
      wdata.count = 8'd1;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[raddr];
    end
  end

  // Request capture and scan tag.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cap <= req;
    end
    pf <= ptr[FW-1:0];
  end

  // Pointer, hint and read-valid tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      hint <= '0;
      pv   <= 1'b0;
    end else begin
      pv <= issue;
      if (ctl.ptr_zero) begin
        ptr <= '0;
      end else if (ctl.ptr_hint) begin
        ptr <= hint;
      end else if (ctl.clear_wr || ctl.init_wr || issue) begin
        ptr <= ptr + (FW+1)'(1);
      end
      // No free frame ever lies below the hint; the free set only shrinks
      // between init sweeps.
      if (ctl.init_wr && stat.sweep_last) begin
        hint <= '0;
      end else if (ctl.alloc_wr) begin
        if (cap.owner_code == pfa_pkg::OWNER_FREE) begin
          hint <= (FW+1)'(pf);
        end else begin
          hint <= (FW+1)'(pf) + (FW+1)'(1);
        end
      end else if (ctl.scan && stat.exhausted) begin
        hint <= NF;
      end
    end
  end

  assign stat.sweep_last = (ptr == NF_LAST);
  assign stat.found      = pv && (rd_q.owner == pfa_pkg::OWNER_FREE);
  assign stat.exhausted  = !pv && (ptr >= NF);
  assign stat.asn_bad    = ((cap.page_address & PMASK) != 32'd0) ||
                           ({1'b0, cap.page_address} >= LIMIT);
  assign stat.asn_busy   = (rd_q.count != 8'd0);
  assign stat.out_free   = !rsp_valid || rsp_ready;

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      case (ctl.res_sel)
        pfa_pkg::RES_NO_FREE: begin
          res.status        <= pfa_pkg::ST_NO_FREE;
          res.frame_address <= '0;
        end
        pfa_pkg::RES_REJECT: begin
          res.status        <= pfa_pkg::ST_REJECT;
          res.frame_address <= '0;
        end
        pfa_pkg::RES_ALLOC: begin
          res.status        <= pfa_pkg::ST_OK;
          res.frame_address <= alloc_addr[pfa_pkg::ADDR_W-1:0];
        end
        pfa_pkg::RES_ASSIGN: begin
          res.status        <= pfa_pkg::ST_OK;
          res.frame_address <= cap.page_address[pfa_pkg::ADDR_W-1:0];
        end
        default: begin
          res.status        <= pfa_pkg::ST_OK;
          res.frame_address <= '0;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_physical_frame_allocator.sv =====
// Self-checking testbench for the physical frame allocator: a directed table, then phased
// random traffic under several region settings, each answer checked against a frame table
// kept here. Depends on pfa_pkg and physical_frame_allocator.

module tb_physical_frame_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import pfa_pkg::*;

  localparam int FRAMES      = 512;
  localparam int PAGE_SHIFT  = 12;
  localparam int IDLE_PCT    = 38;
  // The slowest legal run is about 1450 items at an init sweep or a full scan each,
  // plus stalls on both sides; the limit sits several times above that.
  localparam int CYCLE_LIMIT = 4_000_000;

  // The command encoding leaves one code unused; the block must answer it as a no-op.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One row of the directed table. Where want_typed is set, the answer is the typed one;
  // the frame table is stepped either way so that it stays in line with the block.
  typedef struct packed {
    req_t   item;
    logic   want_typed;
    rsp_t   want;
  } stim_row_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req       = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  physical_frame_allocator #(
    .FRAMES    (FRAMES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Our own copy of the frame table and the region registers.
  logic [7:0] frame_owner [FRAMES];
  logic [7:0] frame_refs  [FRAMES];
  logic [9:0] io_lo   = 10'd160;
  logic [9:0] io_hi   = 10'd256;
  logic [9:0] kern_lo = 10'd64;
  logic [9:0] kern_hi = 10'd96;

  // Answers still owed by the block, oldest first.
  rsp_t pending_rsp [$];

  int   n_err    = 0;
  int   n_items  = 0;
  int   n_phases = 0;
  int   n_nofree = 0;
  int   n_reject = 0;
  int   cycles   = 0;

  // While steady is high neither side inserts idle cycles.
  logic steady    = 1'b0;
  // Typed expectation that travels with the beat currently on the request channel.
  logic row_typed = 1'b0;
  rsp_t row_exp   = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d answers owed", cycles, pending_rsp.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    n_err++;
  endtask

  // Lowest frame whose owner code is free, or -1 when every frame is owned.
  function automatic int lowest_free_frame();
    int f;
    int hit;
    hit = -1;
    for (f = FRAMES - 1; f >= 0; f--) begin
      if (frame_owner[f] == OWNER_FREE) hit = f;
    end
    return hit;
  endfunction

  // Applies one request to the frame table and returns the answer it earns.
  function automatic rsp_t frame_table_step(input req_t item);
    rsp_t        r;
    int          f;
    logic [7:0]  cls;
    logic [31:0] a;
    logic [31:0] byte_addr;
    r = '0;
    a = item.page_address;
    case (item.command)
      CMD_INIT: begin
        // Frame 0 and the I/O hole are reserved; the hole wins over the kernel image.
        for (f = 0; f < FRAMES; f++) begin
          if (f == 0 || (f >= io_lo && f < io_hi)) cls = OWNER_RESERVED;
          else if (f >= kern_lo && f < kern_hi) cls = OWNER_KERNEL;
          else cls = OWNER_FREE;
          frame_owner[f] = cls;
          frame_refs[f]  = (cls != OWNER_FREE) ? 8'd1 : 8'd0;
        end
      end
      CMD_ALLOC: begin
        f = lowest_free_frame();
        if (f < 0) begin
          r.status = ST_NO_FREE;
        end else begin
          // Stamping owner zero keeps the frame free, so it can be handed out again.
          frame_owner[f] = item.owner_code;
          if (frame_refs[f] != 8'hFF) frame_refs[f] = frame_refs[f] + 8'd1;
          byte_addr = 32'(f) << PAGE_SHIFT;
          r.frame_address = byte_addr[ADDR_W-1:0];
        end
      end
      CMD_ASSIGN: begin
        if (a[PAGE_SHIFT-1:0] != '0 || a >= (32'(FRAMES) << PAGE_SHIFT)) begin
          r.status = ST_REJECT;
        end else begin
          f = int'(a >> PAGE_SHIFT);
          if (frame_refs[f] != 8'd0) begin
            r.status = ST_REJECT;
          end else begin
            frame_refs[f]  = 8'd1;
            frame_owner[f] = item.owner_code;
            r.frame_address = a[ADDR_W-1:0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Register values are mostly in the legal 0..512 span, sometimes any 10-bit value.
  function automatic logic [9:0] random_frame_reg();
    logic [31:0] v;
    v = ($urandom_range(99) < 10) ? $urandom() : $urandom_range(FRAMES);
    return v[9:0];
  endfunction

  // Random request. Most assigns aim at well-formed pages, chosen from the table so that
  // both free and busy frames get hit; the rest are misaligned or out of range.
  function automatic req_t pick_request(input logic saturate);
    req_t        it;
    int          roll;
    int          f;
    int          start;
    int          k;
    logic        got;
    logic [31:0] junk;
    it.command      = CMD_ALLOC;
    junk            = $urandom();
    it.owner_code   = ($urandom_range(99) < 15) ? 8'sd0 : junk[7:0];
    it.page_address = $urandom();
    roll            = $urandom_range(99);
    if (saturate) begin
      // Owner zero keeps landing on the same frame and drives its count into the ceiling;
      // the odd assign probes that frame, which must stay busy.
      if (roll < 92) begin
        it.owner_code = 8'sd0;
      end else begin
        f = lowest_free_frame();
        if (f < 0) f = 0;
        it.command      = CMD_ASSIGN;
        it.page_address = 32'(f) << PAGE_SHIFT;
      end
    end else if (roll < 2) begin
      it.command = CMD_INIT;
    end else if (roll < 7) begin
      it.command = CMD_UNUSED;
    end else if (roll >= 50) begin
      it.command = CMD_ASSIGN;
      roll = $urandom_range(99);
      if (roll < 40) begin
        start = $urandom_range(FRAMES - 1);
        f     = start;
        got   = 1'b0;
        for (k = 0; k < FRAMES; k++) begin
          if (!got && frame_refs[(start + k) % FRAMES] == 8'd0) begin
            f   = (start + k) % FRAMES;
            got = 1'b1;
          end
        end
      end else if (roll < 60) begin
        f = lowest_free_frame();
        if (f < 0) f = 0;
      end else begin
        f = $urandom_range(FRAMES - 1);
      end
      it.page_address = 32'(f) << PAGE_SHIFT;
      if (roll >= 75 && roll < 88) begin
        junk = $urandom_range((1 << PAGE_SHIFT) - 1, 1);
        it.page_address[PAGE_SHIFT-1:0] = junk[PAGE_SHIFT-1:0];
      end else if (roll >= 88 && roll < 94) begin
        it.page_address = ($urandom() | (32'(FRAMES) << PAGE_SHIFT)) & ~32'hFFF;
      end else if (roll >= 94) begin
        it.page_address = $urandom();
      end
    end
    return it;
  endfunction

  function automatic stim_row_t mk_row(input logic [1:0] cmd, input logic [7:0] own,
                                       input logic [31:0] addr, input logic typed,
                                       input logic [1:0] st, input logic [ADDR_W-1:0] fa);
    stim_row_t r;
    r.item.command       = cmd;
    r.item.owner_code    = own;
    r.item.page_address  = addr;
    r.want_typed         = typed;
    r.want.status        = st;
    r.want.frame_address = fa;
    return r;
  endfunction

  // Waits for the next falling edge, then idles at random. The first falling edge after
  // an accepted beat either lowers valid here or carries the next beat in drive_beat.
  task automatic wait_slot();
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Presents one beat and holds it until the block takes it.
  task automatic drive_beat(input req_t item, input logic typed, input rsp_t want);
    req_valid <= 1'b1;
    req       <= item;
    row_typed <= typed;
    row_exp   <= want;
    do @(posedge clk); while (!req_ready);
  endtask

  // Drops valid and waits until every owed answer has come back.
  task automatic drain(input int settle);
    @(negedge clk) req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle. The upper data bits carry junk that the
  // register must drop.
  task automatic apb_write(input logic [1:0] idx, input logic [9:0] val);
    logic [31:0] junk;
    junk = $urandom();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[31:10], val};
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_IO_FIRST:  io_lo   = val;
      REG_IO_END:    io_hi   = val;
      REG_KER_FIRST: kern_lo = val;
      REG_KER_END:   kern_hi = val;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // APB read of one register, compared with our copy.
  task automatic apb_check(input logic [1:0] idx);
    logic [31:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_IO_FIRST:  want = {22'd0, io_lo};
      REG_IO_END:    want = {22'd0, io_hi};
      REG_KER_FIRST: want = {22'd0, kern_lo};
      default:       want = {22'd0, kern_hi};
    endcase
    if (prdata !== want) flag_mismatch("register readback", prdata, want);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // The response side stalls at random except during a steady stretch.
  always @(negedge clk) begin
    rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Beat monitor. An accepted request steps the frame table and queues the answer it
  // earns; an accepted response is compared field by field with the oldest one queued.
  always @(posedge clk) begin : beat_monitor
    rsp_t predicted;
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        predicted = frame_table_step(req);
        want      = row_typed ? row_exp : predicted;
        pending_rsp.push_back(want);
        n_items++;
        if (want.status == ST_NO_FREE) n_nofree++;
        if (want.status == ST_REJECT)  n_reject++;
      end
      if (rsp_valid && rsp_ready) begin
        if (pending_rsp.size() == 0) begin
          flag_mismatch("response with nothing owed", 32'(rsp), 32'd0);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.status !== want.status)
            flag_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.frame_address !== want.frame_address)
            flag_mismatch("frame_address", 32'(rsp.frame_address), 32'(want.frame_address));
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t  dir_rows [$];
    req_t       init_req;
    int         p;
    int         i;
    int         n_rand;
    logic       saturate;
    logic       skip_init;
    logic [9:0] c0;
    logic [9:0] c1;
    logic [9:0] c2;
    logic [9:0] c3;

    for (i = 0; i < FRAMES; i++) begin
      frame_owner[i] = OWNER_FREE;
      frame_refs[i]  = 8'd0;
    end

    // Directed table, run with the reset region settings (hole 160..256, kernel 64..96).
    // Before any init every frame is free, so the first alloc gets frame 0.
    dir_rows.push_back(mk_row(CMD_ALLOC,  8'h05, 32'h0000_0000, 1'b1, ST_OK, 21'h000000));
    // Frame 0 now holds a reference, so claiming it is refused.
    dir_rows.push_back(mk_row(CMD_ASSIGN, 8'h03, 32'h0000_0000, 1'b1, ST_REJECT, '0));
    // Last frame in range, largest positive owner.
    dir_rows.push_back(mk_row(CMD_ASSIGN, 8'h7F, 32'h001F_F000, 1'b1, ST_OK, 21'h1FF000));
    // One page past the table, all ones, misaligned, far out of range.
    dir_rows.push_back(mk_row(CMD_ASSIGN, 8'h11, 32'h0020_0000, 1'b1, ST_REJECT, '0));
    dir_rows.push_back(mk_row(CMD_ASSIGN, 8'hFF, 32'hFFFF_FFFF, 1'b1, ST_REJECT, '0));
    dir_rows.push_back(mk_row(CMD_ASSIGN, 8'h22, 32'h0000_1001, 1'b1, ST_REJECT, '0));
    dir_rows.push_back(mk_row(CMD_ASSIGN, 8'h33, 32'h8000_0000, 1'b1, ST_REJECT, '0));
    // The unused command is a no-op that still answers.
    dir_rows.push_back(mk_row(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1, ST_OK, '0));
    dir_rows.push_back(mk_row(CMD_INIT,   8'h80, 32'hFFFF_FFFF, 1'b1, ST_OK, '0));
    // After init frame 0 is reserved, so the lowest free frame is 1.
    dir_rows.push_back(mk_row(CMD_ALLOC,  8'h80, 32'h0000_0000, 1'b1, ST_OK, 21'h001000));
    // Owner zero leaves frame 2 free, so the next alloc returns it again.
    dir_rows.push_back(mk_row(CMD_ALLOC,  8'h00, 32'h0000_0000, 1'b0, ST_OK, '0));
    dir_rows.push_back(mk_row(CMD_ALLOC,  8'h7F, 32'h0000_0000, 1'b0, ST_OK, '0));
    dir_rows.push_back(mk_row(CMD_ALLOC,  8'h01, 32'h1234_5678, 1'b0, ST_OK, '0));
    // Kernel and I/O hole frames carry a count of one after init.
    dir_rows.push_back(mk_row(CMD_ASSIGN, 8'h44, 32'h0004_0000, 1'b1, ST_REJECT, '0));
    dir_rows.push_back(mk_row(CMD_ASSIGN, 8'h44, 32'h000A_0000, 1'b1, ST_REJECT, '0));
    // First frame past the kernel image is free.
    dir_rows.push_back(mk_row(CMD_ASSIGN, 8'hFE, 32'h0006_0000, 1'b1, ST_OK, 21'h060000));
    dir_rows.push_back(mk_row(CMD_ASSIGN, 8'h55, 32'h001F_F000, 1'b1, ST_OK, 21'h1FF000));
    dir_rows.push_back(mk_row(CMD_ASSIGN, 8'h66, 32'h0000_3000, 1'b0, ST_OK, '0));
    // Assign with owner zero: the frame is busy by count yet free by owner.
    dir_rows.push_back(mk_row(CMD_ASSIGN, 8'h00, 32'h0000_4000, 1'b1, ST_OK, 21'h004000));
    dir_rows.push_back(mk_row(CMD_ALLOC,  8'h09, 32'h0000_0000, 1'b0, ST_OK, '0));
    dir_rows.push_back(mk_row(CMD_ALLOC,  8'hAA, 32'hFFFF_FFFF, 1'b0, ST_OK, '0));

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // The block clears its table right after reset; the first beat simply waits for it.
    for (i = 0; i < dir_rows.size(); i++) begin
      wait_slot();
      drive_beat(dir_rows[i].item, dir_rows[i].want_typed, dir_rows[i].want);
    end
    drain(4);

    // Random phases. Each one programs the four region registers, reads them back,
    // runs init in most phases, then a burst of mixed requests.
    for (p = 0; p < 12; p++) begin
      saturate  = 1'b0;
      skip_init = 1'b0;
      n_rand    = 115;
      c0 = random_frame_reg();
      c1 = random_frame_reg();
      c2 = random_frame_reg();
      c3 = random_frame_reg();
      case (p)
        0: begin
          c0 = 10'd160; c1 = 10'd256; c2 = 10'd64; c3 = 10'd96;
        end
        1: begin
          // Empty ranges everywhere: only frame 0 is reserved.
          c0 = 10'd0; c1 = 10'd0; c2 = 10'd0; c3 = 10'd0;
        end
        2: begin
          // The hole covers every frame: allocs find nothing, assigns are all refused.
          c0 = 10'd1; c1 = 10'd512; c2 = 10'd0; c3 = 10'd0;
          n_rand = 30;
        end
        3: begin
          // Hole beyond the table, kernel over all of it: again nothing free.
          c0 = 10'd512; c1 = 10'd1023; c2 = 10'd0; c3 = 10'd1023;
          n_rand = 30;
        end
        4: begin
          // Inverted ranges cover nothing.
          c0 = 10'd300; c1 = 10'd200; c2 = 10'd400; c3 = 10'd100;
        end
        5: begin
          saturate = 1'b1;
          n_rand   = 320;
        end
        7: skip_init = 1'b1;
        default: ;
      endcase
      steady = (p == 6);

      apb_write(REG_IO_FIRST,  c0);
      apb_write(REG_IO_END,    c1);
      apb_write(REG_KER_FIRST, c2);
      apb_write(REG_KER_END,   c3);
      apb_check(REG_IO_FIRST);
      apb_check(REG_IO_END);
      apb_check(REG_KER_FIRST);
      apb_check(REG_KER_END);

      if (!skip_init) begin
        init_req.command      = CMD_INIT;
        init_req.owner_code   = 8'($urandom());
        init_req.page_address = $urandom();
        wait_slot();
        drive_beat(init_req, 1'b0, '0);
      end
      for (i = 0; i < n_rand; i++) begin
        wait_slot();
        drive_beat(pick_request(saturate), 1'b0, '0);
      end
      drain(4);
      n_phases++;
    end
    steady = 1'b0;

    // Let a late or extra answer show itself: up to one init sweep plus margin.
    drain(FRAMES + 16);

    $display("covered %0d requests: directed table, then %0d register phases", n_items,
             n_phases);
    $display("answers with no free frame: %0d, rejected assigns: %0d, mismatches: %0d",
             n_nofree, n_reject, n_err);
    if (n_err == 0 && pending_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_ctrl.sv
hw/rtl/pfa_dp.sv
hw/rtl/physical_frame_allocator.sv
dv/tb_physical_frame_allocator.sv
